FILE: hdl/isc_pkg.sv
// Package for the integer set table: sizes, operation and status codes,
// the per-cell control bundle and the width helpers.
// Used by every module in this folder; depends on nothing.
package isc_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  localparam int WORD_W = 32;
  localparam int PICK_W = 16;
  localparam int COUNT_W = 5;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int XW     = (VALUE_BITS > WORD_W) ? VALUE_BITS : WORD_W;
  localparam int CW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Remainder unit: bits retired per cycle and iteration steps per extract.
  localparam int DIG    = 4;
  localparam int ITER   = PICK_W / DIG;
  localparam int ITER_W = $clog2(ITER + 1);

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_MEMBER  = 2'd2,
    KIND_EXTRACT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic                  add_en;
    logic                  drop_en;
    logic [IDX_W-1:0]      pos;
    logic [VALUE_BITS-1:0] key;
    logic [CNT_W-1:0]      cnt;
  } cell_ctrl_t;

  function automatic logic [VALUE_BITS-1:0] to_key(input logic [WORD_W-1:0] w);
    logic [XW-1:0] t;
    t = XW'(w);
    return t[VALUE_BITS-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] to_word(input logic [VALUE_BITS-1:0] v);
    logic [XW-1:0] t;
    t = XW'(v);
    return t[WORD_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    logic [CW-1:0] t;
    t = CW'(c);
    return t[COUNT_W-1:0];
  endfunction

endpackage

FILE: hdl/isc_cell.sv
// One slot of the set table: holds a value, compares it with the key and
// takes its neighbor's value when the row shifts. Depends on isc_pkg.
module isc_cell (
  input  logic                          clk_i,
  input  logic [isc_pkg::IDX_W-1:0]     idx_i,
  input  isc_pkg::cell_ctrl_t           ctrl_i,
  input  logic [isc_pkg::VALUE_BITS-1:0] left_i,
  input  logic [isc_pkg::VALUE_BITS-1:0] right_i,
  output logic [isc_pkg::VALUE_BITS-1:0] value_o,
  output logic                          match_o
);
  import isc_pkg::*;

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  live;

  assign live    = CNT_W'(idx_i) < ctrl_i.cnt;
  assign match_o = live && (value_q == ctrl_i.key);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.add_en) begin
      value_d = (idx_i == '0) ? ctrl_i.key : left_i;
    end else if (ctrl_i.drop_en && (idx_i >= ctrl_i.pos)) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: hdl/isc_mod.sv
// Iterative remainder unit: pick modulo count, several bits per cycle.
// Depends on isc_pkg.
module isc_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [isc_pkg::PICK_W-1:0]   pick_i,
  input  logic [isc_pkg::CNT_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [isc_pkg::IDX_W-1:0]    rem_o
);
  import isc_pkg::*;

  logic                busy_q, busy_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic [PICK_W-1:0]   num_q, num_d;
  logic [CNT_W-1:0]    rem_q, rem_d, div_q, div_d;
  logic [CNT_W-1:0]    step_rem;
  logic [CNT_W:0]      trial;

  always_comb begin
    step_rem = rem_q;
    for (int b = 0; b < DIG; b++) begin
      trial = {step_rem, num_q[PICK_W-1-b]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      step_rem = trial[CNT_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    iter_d = iter_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      num_d  = pick_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = step_rem;
      num_d  = num_q << DIG;
      iter_d = iter_q + 1'b1;
      if (iter_q == ITER_W'(ITER - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

FILE: hdl/integer_set_table.sv
// Top level of the integer set table: a row of slot cells, the remainder
// unit for extract and the operation sequencer. Depends on isc_pkg,
// isc_cell and isc_mod.
//
// The table holds up to CAPACITY distinct values, newest first. An input
// beat carries an operation kind (add, remove, member query, extract), a
// value and a pick used as the extract position modulo the current count.
// Every accepted beat yields exactly one output beat with a status, the
// extracted value (zero unless an extract succeeds), the new count and an
// empty flag.
// The slot cells compare against the incoming value in the cycle of
// acceptance, so add, remove and member go from the accept-and-compare
// IDLE state to APPLY, which shifts the row and loads the output register.
// Extract on a non-empty table also waits for the remainder unit, which
// retires four bits of pick per cycle, before it reaches APPLY.
// One operation is in flight at a time; the input stall is high from
// acceptance until the result is written to the output register.
// The output register lets the next beat be accepted while a result
// waits. If the receiver stalls while a result waits, the next result
// holds in the sequencer until the output register frees.
// Reset empties the table at once; slot contents are not cleared.
module integer_set_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                in_kind_i,
  input  logic signed [31:0]        in_value_i,
  input  logic [15:0]               in_pick_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                out_status_o,
  output logic signed [31:0]        out_extracted_value_o,
  output logic [4:0]                out_count_o,
  output logic                      out_is_empty_o
);
  import isc_pkg::*;

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CAPACITY-1:0]   match_q, match_d;
  logic [CAPACITY-1:0]   match_w;
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  cell_ctrl_t            ctrl;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [WORD_W-1:0]     out_value_q, out_value_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;
  logic                  out_empty_q, out_empty_d;

  logic                  accept, mod_start, mod_busy, found, advance;
  logic [IDX_W-1:0]      mod_rem, pos_enc, pos_sel;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign mod_start = accept && (kind_e'(in_kind_i) == KIND_EXTRACT) && (cnt_q != '0);
  assign advance   = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);
  assign found     = |match_q;

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) begin
        pos_enc = pos_enc | IDX_W'(i);
      end
    end
  end

  assign pos_sel = (kind_q == KIND_EXTRACT) ? mod_rem : pos_enc;

  isc_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .pick_i    (in_pick_i),
    .divisor_i (cnt_q),
    .busy_o    (mod_busy),
    .rem_o     (mod_rem)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = ctrl.key;
    end else begin : g_mid
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_inner
      assign right_v = cell_val[g+1];
    end
    isc_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[g]),
      .match_o (match_w[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    match_d      = match_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;

    ctrl.add_en  = 1'b0;
    ctrl.drop_en = 1'b0;
    ctrl.pos     = pos_sel;
    ctrl.key     = (state_q == S_IDLE) ? to_key(in_value_i) : key_q;
    ctrl.cnt     = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = kind_e'(in_kind_i);
          key_d   = to_key(in_value_i);
          match_d = match_w;
          state_d = mod_start ? S_MOD : S_APPLY;
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (advance) begin
          out_status_d = STATUS_OK;
          out_value_d  = '0;
          case (kind_q)
            KIND_ADD: begin
              if (found) begin
                out_status_d = STATUS_MISS;
              end else if (cnt_q >= CNT_W'(CAPACITY)) begin
                out_status_d = STATUS_FULL;
              end else begin
                ctrl.add_en = 1'b1;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (found) begin
                ctrl.drop_en = 1'b1;
                cnt_d        = cnt_q - 1'b1;
              end else begin
                out_status_d = STATUS_MISS;
              end
            end
            KIND_MEMBER: begin
              out_status_d = found ? STATUS_OK : STATUS_MISS;
            end
            KIND_EXTRACT: begin
              if (cnt_q == '0) begin
                out_status_d = STATUS_MISS;
              end else begin
                ctrl.drop_en = 1'b1;
                cnt_d        = cnt_q - 1'b1;
                out_value_d  = to_word(cell_val[pos_sel]);
              end
            end
            default: begin
              out_status_d = STATUS_MISS;
            end
          endcase
          out_valid_d = 1'b1;
          out_count_d = to_count(cnt_d);
          out_empty_d = (cnt_d == '0);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    match_q      <= match_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_status_q;
  assign out_extracted_value_o = out_value_q;
  assign out_count_o           = out_count_q;
  assign out_is_empty_o        = out_empty_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("Element count exceeds capacity.");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> $onehot0(match_q))
    else $error("More than one live slot matches the key.");

  a_mod_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> (state_q == S_MOD))
    else $error("Remainder unit busy outside its wait state.");

  a_out_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_APPLY))
    else $error("Output beat raised without an apply step.");

endmodule
